### src/mcqe_pkg.sv
package mcqe_pkg;

  // Channel and buffer geometry.
  localparam int NUM_CHANNELS = 4;
  localparam int MAX_DEPTH    = 16;
  localparam int CHAN_W       = $clog2(NUM_CHANNELS);
  localparam int PTR_W        = $clog2(MAX_DEPTH);
  localparam int CAP_W        = 5;
  localparam int SLOT_DEPTH   = NUM_CHANNELS * MAX_DEPTH;
  localparam int SLOT_ADDR_W  = CHAN_W + PTR_W;
  localparam int DATA_W       = 64;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CAP_W;

  // Action codes.
  localparam logic [2:0] ACT_SEND   = 3'd0;
  localparam logic [2:0] ACT_RECV   = 3'd1;
  localparam logic [2:0] ACT_CLOSE  = 3'd2;
  localparam logic [2:0] ACT_QUERY  = 3'd3;
  localparam logic [2:0] ACT_SELECT = 3'd4;
  localparam logic [2:0] ACT_POLL   = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BLOCK   = 2'd1;
  localparam logic [1:0] ST_CLOSED  = 2'd2;
  localparam logic [1:0] ST_PENDING = 2'd3;

  // One input transaction.
  typedef struct packed {
    logic [2:0]               action;
    logic [1:0]               chan_index;
    logic signed [DATA_W-1:0] send_value;
    logic [3:0]               chan_mask;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] recv_value;
    logic [1:0]               chosen_chan;
    logic                     is_closed;
  } out_item_t;

  // Result of one processed transaction, before the slot store data is merged in.
  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        chosen_chan;
    logic              is_closed;
    logic              from_ram;
    logic [DATA_W-1:0] handoff_data;
  } eng_res_t;

  // Slot store access request.
  typedef struct packed {
    logic                   wr_en;
    logic [SLOT_ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0]      wr_data;
    logic                   rd_en;
    logic [SLOT_ADDR_W-1:0] rd_addr;
  } ram_req_t;

endpackage

### src/mcqe_ram.sv
module mcqe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port; read data holds when not read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/mcqe_engine.sv
module mcqe_engine
  import mcqe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  fire,
  input  in_item_t              item,
  output eng_res_t              res,
  output ram_req_t              ram_req
);

  logic [CAP_W-1:0]  cap_r         [NUM_CHANNELS];
  logic [PTR_W-1:0]  wr_ptr_r      [NUM_CHANNELS];
  logic [PTR_W-1:0]  wr_ptr_nxt    [NUM_CHANNELS];
  logic [PTR_W-1:0]  rd_ptr_r      [NUM_CHANNELS];
  logic [PTR_W-1:0]  rd_ptr_nxt    [NUM_CHANNELS];
  logic [CAP_W-1:0]  fill_r        [NUM_CHANNELS];
  logic [CAP_W-1:0]  fill_nxt      [NUM_CHANNELS];
  logic [DATA_W-1:0] hv_r          [NUM_CHANNELS];
  logic [DATA_W-1:0] hv_nxt        [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] closed_r, closed_nxt;
  logic [NUM_CHANNELS-1:0] hfull_r, hfull_nxt;
  logic [NUM_CHANNELS-1:0] htaken_r, htaken_nxt;

  logic [CAP_W-1:0]        cap_eff [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] has_data;
  logic [CHAN_W-1:0]       ch;
  logic [CAP_W-1:0]        ch_cap;
  logic                    ch_full;
  logic                    sel_hit;
  logic [CHAN_W-1:0]       sel_ch;
  logic                    take_en;
  logic [CHAN_W-1:0]       take_ch;

  // Pointer advance that wraps at the channel's effective capacity.
  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p,
                                            input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] p1;
    p1 = CAP_W'(p) + CAP_W'(1);
    bump = (p1 >= cap) ? '0 : p1[PTR_W-1:0];
  endfunction

  // Capacity clamp and per-channel data presence.
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      cap_eff[i]  = (cap_r[i] > CAP_W'(MAX_DEPTH)) ? CAP_W'(MAX_DEPTH) : cap_r[i];
      has_data[i] = (cap_eff[i] == '0) ? hfull_r[i] : (fill_r[i] != '0);
    end
  end

  assign ch      = item.chan_index[CHAN_W-1:0];
  assign ch_cap  = cap_eff[ch];
  assign ch_full = (fill_r[ch] >= ch_cap);

  // Select picks the lowest-numbered masked channel holding data.
  always_comb begin
    sel_hit = 1'b0;
    sel_ch  = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (!sel_hit && item.chan_mask[i] && has_data[i]) begin
        sel_hit = 1'b1;
        sel_ch  = CHAN_W'(i);
      end
    end
  end

  // Decision logic and next state for the transaction in the input register.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    hv_nxt     = hv_r;
    closed_nxt = closed_r;
    hfull_nxt  = hfull_r;
    htaken_nxt = htaken_r;

    res              = '0;
    ram_req          = '0;
    ram_req.wr_addr  = {ch, wr_ptr_r[ch]};
    ram_req.wr_data  = item.send_value;
    take_en          = 1'b0;
    take_ch          = ch;

    case (item.action)
      ACT_SEND: begin
        if (closed_r[ch]) begin
          res.status = ST_CLOSED;
        end else if (ch_cap == '0) begin
          if (hfull_r[ch]) begin
            res.status = ST_BLOCK;
          end else begin
            hv_nxt[ch]     = item.send_value;
            hfull_nxt[ch]  = 1'b1;
            htaken_nxt[ch] = 1'b0;
            res.status     = ST_PENDING;
          end
        end else if (ch_full) begin
          res.status = ST_BLOCK;
        end else begin
          ram_req.wr_en  = fire;
          wr_ptr_nxt[ch] = bump(wr_ptr_r[ch], ch_cap);
          fill_nxt[ch]   = fill_r[ch] + CAP_W'(1);
          res.status     = ST_OK;
        end
      end
      ACT_RECV: begin
        if (has_data[ch]) begin
          take_en    = 1'b1;
          res.status = ST_OK;
        end else begin
          res.status = closed_r[ch] ? ST_CLOSED : ST_BLOCK;
        end
      end
      ACT_CLOSE: begin
        closed_nxt[ch] = 1'b1;
        hfull_nxt[ch]  = 1'b0;
        htaken_nxt[ch] = 1'b0;
        res.status     = ST_OK;
      end
      ACT_SELECT: begin
        if (sel_hit) begin
          take_en         = 1'b1;
          take_ch         = sel_ch;
          res.chosen_chan = 2'(sel_ch);
          res.status      = ST_OK;
        end else begin
          res.status = ST_BLOCK;
        end
      end
      ACT_POLL: begin
        if (ch_cap == '0) begin
          if (hfull_r[ch]) begin
            res.status = ST_PENDING;
          end else begin
            res.status = closed_r[ch] ? ST_CLOSED : ST_OK;
          end
        end else if (closed_r[ch]) begin
          res.status = ST_CLOSED;
        end else begin
          res.status = ch_full ? ST_BLOCK : ST_OK;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase

    // Taking a value: from the hand-off slot or from the ring in the slot store.
    ram_req.rd_addr = {take_ch, rd_ptr_r[take_ch]};
    if (take_en) begin
      if (cap_eff[take_ch] == '0) begin
        res.handoff_data        = hv_r[take_ch];
        hfull_nxt[take_ch]      = 1'b0;
        htaken_nxt[take_ch]     = 1'b1;
      end else begin
        res.from_ram            = 1'b1;
        ram_req.rd_en           = fire;
        rd_ptr_nxt[take_ch]     = bump(rd_ptr_r[take_ch], cap_eff[take_ch]);
        fill_nxt[take_ch]       = fill_r[take_ch] - CAP_W'(1);
      end
    end

    res.is_closed = closed_nxt[ch];
  end

  // Capacity registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cap_r[i] <= '0;
      end
    end else if (cfg_wen) begin
      cap_r[cfg_index] <= cfg_wdata;
    end
  end

  // Channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wr_ptr_r[i] <= '0;
        rd_ptr_r[i] <= '0;
        fill_r[i]   <= '0;
        hv_r[i]     <= '0;
      end
      closed_r <= '0;
      hfull_r  <= '0;
      htaken_r <= '0;
    end else if (fire) begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
      hv_r     <= hv_nxt;
      closed_r <= closed_nxt;
      hfull_r  <= hfull_nxt;
      htaken_r <= htaken_nxt;
    end
  end

  // A hand-off slot is never both full and marked taken.
  a_handoff_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (hfull_r & htaken_r) == '0)
    else $error("hand-off slot full and taken at once");

  // One transaction either writes or reads the slot store, never both.
  a_ram_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.wr_en && ram_req.rd_en))
    else $error("slot store written and read by one transaction");

  // Closed flags only change when a transaction is processed.
  a_closed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(closed_r))
    else $error("closed flag changed without a transaction");

  // Fill counts never exceed MAX_DEPTH, the largest ring size.
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_fill_chk
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
      fill_r[g] <= CAP_W'(MAX_DEPTH))
      else $error("fill count above ring size");
  end

endmodule

### src/multi_channel_queue_engine_top.sv
// Multi-channel message queue engine.
// Input channel (in_valid, in_stall, in_data): one transaction carries an action
// (send, receive, close, query closed, select, poll send), a channel index, a
// 64-bit value and a select mask. Result channel (out_valid, out_stall,
// out_data): exactly one result transaction per input transaction, in order.
// Configuration port (cfg_wen, cfg_index, cfg_wdata): capacity of each channel,
// to be written only while the engine is idle (the block does not enforce this);
// zero gives a rendezvous hand-off slot. An accepted transaction sits in the
// input register, where the whole action is decided and channel state updated,
// and moves to the result register once that register is free, together with
// any slot store read data. Throughput is one transaction per cycle while the
// receiver does not stall; the slot store has one write and one read port and
// each transaction uses at most one of them.
// Reset clears all channel state and sets every capacity to zero; no
// transactions are in flight afterwards. When the receiver stalls, the result
// stays on out_data, the input register may still fill, and in_stall rises
// once both registers hold a transaction.
module multi_channel_queue_engine_top
  import mcqe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic        in_valid_r, in_valid_nxt;
  in_item_t    in_item_r;
  logic        out_valid_r, out_valid_nxt;
  eng_res_t    res_r;
  eng_res_t    eng_res;
  ram_req_t    ram_req;
  logic [DATA_W-1:0] ram_rd_data;
  logic        fire;
  logic        in_take;

  // Pipeline control: the input register moves on when the result register frees up.
  assign fire     = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (fire) begin
      res_r <= eng_res;
    end
  end

  mcqe_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (in_item_r),
    .res       (eng_res),
    .ram_req   (ram_req)
  );

  mcqe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_store (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

  // Result transaction; ring values come straight from the slot store read register.
  assign out_valid            = out_valid_r;
  assign out_data.status      = res_r.status;
  assign out_data.recv_value  = res_r.from_ram ? ram_rd_data : res_r.handoff_data;
  assign out_data.chosen_chan = res_r.chosen_chan;
  assign out_data.is_closed   = res_r.is_closed;

endmodule
